// File: rtl/core/otm_pkg.sv
// Shared types and codes for the Otsu threshold / RGB mask block.
// No dependencies; imported by otsu_threshold_rgb_mask and the bench.
package otm_pkg;

	// request codes on req_type
	localparam logic REQ_HIST     = 1'b0;
	localparam logic REQ_CLASSIFY = 1'b1;

	// result codes on result_kind
	localparam logic KIND_THRESH = 1'b0;
	localparam logic KIND_MASK   = 1'b1;

	localparam logic [7:0] MASK_ON   = 8'd255;
	localparam logic [7:0] MASK_OFF  = 8'd0;
	localparam logic [7:0] THRESH_MAX = 8'd255;

	localparam logic [1:0] LAST_CHAN = 2'd2;

	// sequencer states, one-hot
	typedef enum logic [14:0] {
		S_CLEAR = 15'h0001,
		S_IDLE  = 15'h0002,
		S_H1    = 15'h0004,
		S_H2    = 15'h0008,
		S_H3    = 15'h0010,
		S_P1    = 15'h0020,
		S_P1E   = 15'h0040,
		S_RD    = 15'h0080,
		S_ACC   = 15'h0100,
		S_CHK   = 15'h0200,
		S_LOAD  = 15'h0400,
		S_MUL   = 15'h0800,
		S_DONE  = 15'h1000,
		S_EMIT  = 15'h2000,
		S_SPARE = 15'h4000
	} state_t;

	// products computed for one candidate split
	typedef enum logic [2:0] {
		OP_A   = 3'd0,   // s1 * n0
		OP_B   = 3'd1,   // s0 * n1
		OP_NUM = 3'd2,   // |a - b|^2
		OP_DEN = 3'd3,   // n0 * n1
		OP_LHS = 3'd4,   // num * best_den
		OP_RHS = 3'd5    // best_num * den
	} op_t;

endpackage

// File: rtl/core/otsu_threshold_rgb_mask.sv
// Otsu threshold finder with RGB mask classifier: histogram memory, search
// sequencer and a shared shift-add multiplier. Depends on otm_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel request. A histogram
//   request (req_type 0) adds its three channel values to per-channel bins;
//   one with last_pixel set starts the threshold search. A classify request
//   (req_type 1) returns mask 255 when every channel is above its threshold.
//   Output channel (out_valid / out_stall) carries one result from one register.
//   A histogram request holds off further requests while it makes three
//   read-modify-write steps on the bin memory. A classify request leaves
//   the block idle; its result is valid the cycle after acceptance.
//   Search per channel: a totals pass over all bins, then per bin a read, an
//   accumulate and, but for the last bin, a check, then a store of the
//   threshold. Each split with two non-empty classes adds six products, each
//   a load step, one shift-add per multiplier bit and a store step. The bins
//   are cleared during the search; the result then leaves through S_EMIT.
//   Reset: a clearing pass over all 3*LEVELS bins zeroes the memory; no request
//   is accepted until it ends. Thresholds reset to zero. A stalled output holds;
//   a classify request then waits, as does the threshold result of a search.
module otsu_threshold_rgb_mask
	import otm_pkg::*;
#(
	parameter int LEVELS     = 256,
	parameter int COUNT_BITS = 23
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [7:0] chan0_value,
	input  logic [7:0] chan1_value,
	input  logic [7:0] chan2_value,
	input  logic       last_pixel,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       result_kind,
	output logic [7:0] thresh0,
	output logic [7:0] thresh1,
	output logic [7:0] thresh2,
	output logic [7:0] mask_value
);

	localparam int LB    = $clog2(LEVELS);
	localparam int DEPTH = 3 * LEVELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = COUNT_BITS;
	localparam int NW    = CB + LB;
	localparam int SW    = CB + 2 * LB;
	localparam int PA    = SW + NW;
	localparam int DW    = 2 * NW;
	localparam int MW    = (PA > DW) ? PA : DW;
	localparam int PW    = 2 * PA + DW;

	state_t state_q;
	op_t    op_q;

	logic [CB-1:0] mem [DEPTH];
	logic [CB-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr, clr_q;
	logic [CB-1:0] wdata;
	logic          mem_we;

	logic [LB-1:0] lvl0_in, lvl1_q, lvl2_q, lvl0_q;
	logic          last_q;
	logic [1:0]    chan_q;
	logic [LB-1:0] idx_q, p1k_s1;
	logic          pend_q;

	logic [NW-1:0] n_all_q, n0_q, n1, n0_new;
	logic [SW-1:0] s_all_q, s0_q, s1, prod_kb;
	logic [PA-1:0] a_q, b_q, diff;
	logic [2*PA-1:0] num_q, best_num_q;
	logic [DW-1:0] den_q, best_den_q;
	logic [PW-1:0] lhs_q, acc_q, mc_q;
	logic [MW-1:0] mp_q;
	logic [LB-1:0] best_k_q;
	logic [LB+7:0] best_kx;
	logic [7:0]    thr_new;
	logic [7:0]    thr_q [3];
	logic [CB-1:0] bin_inc;

	logic       out_valid_q, kind_q;
	logic [7:0] t0_q, t1_q, t2_q, mask_q;
	logic       in_acc, out_free, out_set;

	function automatic logic [LB-1:0] clamp_lvl(input logic [7:0] v);
		logic [LB+7:0] vx;
		vx = (LB+8)'(v);
		return (vx >= (LB+8)'(LEVELS)) ? LB'(LEVELS - 1) : vx[LB-1:0];
	endfunction

	function automatic logic [AW-1:0] bin_addr(input logic [1:0] c, input logic [LB-1:0] l);
		return AW'(c) * AW'(LEVELS) + AW'(l);
	endfunction

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || (req_type == REQ_CLASSIFY && !out_free);
	assign in_acc   = in_valid && !in_stall;
	assign lvl0_in  = clamp_lvl(chan0_value);
	assign out_set  = (state_q == S_IDLE && in_acc && req_type == REQ_CLASSIFY) ||
		(state_q == S_EMIT && out_free);

	// datapath helpers
	assign bin_inc = (rdata_q == {CB{1'b1}}) ? rdata_q : rdata_q + 1'b1;
	assign prod_kb = SW'((state_q == S_ACC) ? idx_q : p1k_s1) * SW'(rdata_q);
	assign n0_new  = n0_q + NW'(rdata_q);
	assign n1      = n_all_q - n0_q;
	assign s1      = s_all_q - s0_q;
	assign diff    = (a_q >= b_q) ? a_q - b_q : b_q - a_q;
	assign best_kx = (LB+8)'(best_k_q);
	assign thr_new = (best_kx > (LB+8)'(THRESH_MAX)) ? THRESH_MAX : best_kx[7:0];

	// memory port selection
	always_comb begin
		raddr  = bin_addr(chan_q, idx_q);
		waddr  = bin_addr(chan_q, idx_q);
		wdata  = '0;
		mem_we = 1'b0;
		case (state_q)
			S_CLEAR: begin
				waddr  = clr_q;
				mem_we = 1'b1;
			end
			S_IDLE: raddr = bin_addr(2'd0, lvl0_in);
			S_H1: begin
				raddr  = bin_addr(2'd1, lvl1_q);
				waddr  = bin_addr(2'd0, lvl0_q);
				wdata  = bin_inc;
				mem_we = 1'b1;
			end
			S_H2: begin
				raddr  = bin_addr(2'd2, lvl2_q);
				waddr  = bin_addr(2'd1, lvl1_q);
				wdata  = bin_inc;
				mem_we = 1'b1;
			end
			S_H3: begin
				waddr  = bin_addr(2'd2, lvl2_q);
				wdata  = bin_inc;
				mem_we = 1'b1;
			end
			S_ACC: mem_we = 1'b1;
			default: ;
		endcase
	end

	// bin memory, one read and one write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			chan_q      <= '0;
			idx_q       <= '0;
			op_q        <= OP_A;
			thr_q[0]    <= '0;
			thr_q[1]    <= '0;
			thr_q[2]    <= '0;
		end else begin
			pend_q <= (state_q == S_P1);
			if (out_valid_q && !out_stall && !out_set) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && req_type == REQ_CLASSIFY) begin
						out_valid_q <= 1'b1;
					end else if (in_acc) begin
						state_q <= S_H1;
					end
				end
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: begin
					chan_q  <= '0;
					idx_q   <= '0;
					state_q <= last_q ? S_P1 : S_IDLE;
				end
				S_P1: begin
					if (idx_q == LB'(LEVELS - 1)) begin
						state_q <= S_P1E;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_P1E: begin
					idx_q   <= '0;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_ACC;
				S_ACC: state_q <= (idx_q == LB'(LEVELS - 1)) ? S_DONE : S_CHK;
				S_CHK: begin
					if (n0_q == '0 || n1 == '0) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end else begin
						op_q    <= OP_A;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: state_q <= S_MUL;
				S_MUL: begin
					if (mp_q == '0) begin
						case (op_q)
							OP_A:   op_q <= OP_B;
							OP_B:   op_q <= OP_NUM;
							OP_NUM: op_q <= OP_DEN;
							OP_DEN: op_q <= OP_LHS;
							OP_LHS: op_q <= OP_RHS;
							default: op_q <= OP_A;
						endcase
						if (op_q == OP_RHS) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_DONE: begin
					thr_q[chan_q] <= thr_new;
					idx_q <= '0;
					if (chan_q == LAST_CHAN) begin
						state_q <= S_EMIT;
					end else begin
						chan_q  <= chan_q + 1'b1;
						state_q <= S_P1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				lvl0_q <= lvl0_in;
				lvl1_q <= clamp_lvl(chan1_value);
				lvl2_q <= clamp_lvl(chan2_value);
				last_q <= last_pixel;
				if (in_acc && req_type == REQ_CLASSIFY) begin
					kind_q <= KIND_MASK;
					t0_q   <= thr_q[0];
					t1_q   <= thr_q[1];
					t2_q   <= thr_q[2];
					mask_q <= (chan0_value > thr_q[0] && chan1_value > thr_q[1] &&
						chan2_value > thr_q[2]) ? MASK_ON : MASK_OFF;
				end
			end
			S_H3: begin
				n_all_q <= '0;
				s_all_q <= '0;
			end
			S_P1, S_P1E: begin
				p1k_s1 <= idx_q;
				if (pend_q) begin
					n_all_q <= n_all_q + NW'(rdata_q);
					s_all_q <= s_all_q + prod_kb;
				end
				n0_q       <= '0;
				s0_q       <= '0;
				best_num_q <= '0;
				best_den_q <= DW'(1);
				best_k_q   <= '0;
			end
			S_ACC: begin
				n0_q <= n0_new;
				s0_q <= s0_q + prod_kb;
			end
			S_LOAD: begin
				acc_q <= '0;
				case (op_q)
					OP_A: begin
						mc_q <= PW'(s1);
						mp_q <= MW'(n0_q);
					end
					OP_B: begin
						mc_q <= PW'(s0_q);
						mp_q <= MW'(n1);
					end
					OP_NUM: begin
						mc_q <= PW'(diff);
						mp_q <= MW'(diff);
					end
					OP_DEN: begin
						mc_q <= PW'(n0_q);
						mp_q <= MW'(n1);
					end
					OP_LHS: begin
						mc_q <= PW'(num_q);
						mp_q <= MW'(best_den_q);
					end
					default: begin
						mc_q <= PW'(best_num_q);
						mp_q <= MW'(den_q);
					end
				endcase
			end
			S_MUL: begin
				if (mp_q != '0) begin
					// shift-add one multiplier bit
					if (mp_q[0]) begin
						acc_q <= acc_q + mc_q;
					end
					mc_q <= mc_q << 1;
					mp_q <= mp_q >> 1;
				end else begin
					case (op_q)
						OP_A:   a_q   <= acc_q[PA-1:0];
						OP_B:   b_q   <= acc_q[PA-1:0];
						OP_NUM: num_q <= acc_q[2*PA-1:0];
						OP_DEN: den_q <= acc_q[DW-1:0];
						OP_LHS: lhs_q <= acc_q;
						default: begin
							// keep the first split with the largest variance
							if (lhs_q > acc_q) begin
								best_num_q <= num_q;
								best_den_q <= den_q;
								best_k_q   <= idx_q + 1'b1;
							end
						end
					endcase
				end
			end
			S_DONE: begin
				n_all_q <= '0;
				s_all_q <= '0;
			end
			S_EMIT: begin
				if (out_free) begin
					kind_q <= KIND_THRESH;
					t0_q   <= thr_q[0];
					t1_q   <= thr_q[1];
					t2_q   <= thr_q[2];
					mask_q <= MASK_OFF;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign thresh0     = t0_q;
	assign thresh1     = t1_q;
	assign thresh2     = t2_q;
	assign mask_value  = mask_q;

`ifndef SYNTH
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> state_q == S_IDLE)
		else $error("request accepted while busy");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("bin write while idle");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !out_valid_q && in_stall)
		else $error("activity during clearing pass");
	a_mul_runs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL && mp_q != '0 |=> state_q == S_MUL)
		else $error("multiply left early");
`endif

endmodule

// File: bench/tb.sv
// Self-checking bench for otsu_threshold_rgb_mask: directed and random frames of histogram
// requests with classify requests between them, checked against an in-bench
// Otsu predictor. Depends on otm_pkg and the block under test.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import otm_pkg::*;

	localparam int NUM_LEVELS = 256;
	localparam int CNT_BITS   = 23;
	localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
	localparam int RAND_ITEMS = 1550;
	localparam int HOLD_AT    = 400;
	localparam int HOLD_LEN   = 600;

	typedef struct packed {
		logic       req;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic       last;
	} pixel_req_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] t0;
		logic [7:0] t1;
		logic [7:0] t2;
		logic [7:0] mask;
	} otsu_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       req_type = REQ_HIST;
	logic [7:0] chan0_value = '0;
	logic [7:0] chan1_value = '0;
	logic [7:0] chan2_value = '0;
	logic       last_pixel = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b1;
	logic       result_kind;
	logic [7:0] thresh0, thresh1, thresh2, mask_value;

	otsu_threshold_rgb_mask #(.LEVELS(NUM_LEVELS), .COUNT_BITS(CNT_BITS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .chan0_value(chan0_value), .chan1_value(chan1_value),
		.chan2_value(chan2_value), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .thresh0(thresh0), .thresh1(thresh1),
		.thresh2(thresh2), .mask_value(mask_value)
	);

	always #5 clk = ~clk;

	pixel_req_t      pending_reqs[$];
	otsu_result_t    expected_results[$];
	longint unsigned hist_bins[3][NUM_LEVELS];
	longint unsigned frame_pixels;
	logic [7:0]      thresh_regs[3];
	int              n_accepted = 0;
	int              n_results = 0;
	int              n_frames = 0;
	int              n_errors = 0;
	logic            in_fire = 1'b0;
	logic            hold_active = 1'b0;

	// Otsu split for one channel: first k with the largest between-class variance
	function automatic logic [7:0] otsu_split(input int ch);
		logic [255:0] n_all, s_all, n0, s0, n1, s1, a, b, diff, num, den, lhs, rhs;
		logic [255:0] best_num, best_den;
		int best_k;
		n_all = '0; s_all = '0; n0 = '0; s0 = '0;
		best_num = '0; best_den = 256'(1); best_k = 0;
		for (int k = 0; k < NUM_LEVELS; k++) begin
			n_all += 256'(hist_bins[ch][k]);
			s_all += 256'(k) * 256'(hist_bins[ch][k]);
		end
		for (int k = 1; k < NUM_LEVELS; k++) begin
			n0 += 256'(hist_bins[ch][k-1]);
			s0 += 256'(k - 1) * 256'(hist_bins[ch][k-1]);
			n1 = n_all - n0;
			s1 = s_all - s0;
			if (n0 != 0 && n1 != 0) begin
				a = s1 * n0;
				b = s0 * n1;
				diff = (a > b) ? a - b : b - a;
				num = diff * diff;
				den = n0 * n1;
				lhs = num * best_den;
				rhs = best_num * den;
				if (lhs > rhs) begin
					best_num = num;
					best_den = den;
					best_k = k;
				end
			end
		end
		return (best_k > 255) ? THRESH_MAX : 8'(best_k);
	endfunction

	// Advance the predicted state by one accepted request
	task automatic predict_request(input pixel_req_t r);
		otsu_result_t e;
		logic [7:0] ch[3];
		ch[0] = r.c0; ch[1] = r.c1; ch[2] = r.c2;
		if (r.req == REQ_CLASSIFY) begin
			e.kind = KIND_MASK;
			e.t0 = thresh_regs[0]; e.t1 = thresh_regs[1]; e.t2 = thresh_regs[2];
			e.mask = (ch[0] > thresh_regs[0] && ch[1] > thresh_regs[1] &&
				ch[2] > thresh_regs[2]) ? MASK_ON : MASK_OFF;
			expected_results.push_back(e);
		end else begin
			for (int c = 0; c < 3; c++)
				if (hist_bins[c][ch[c]] < CNT_MAX) hist_bins[c][ch[c]]++;
			if (frame_pixels < CNT_MAX) frame_pixels++;
			if (r.last) begin
				for (int c = 0; c < 3; c++) thresh_regs[c] = otsu_split(c);
				for (int c = 0; c < 3; c++)
					for (int k = 0; k < NUM_LEVELS; k++) hist_bins[c][k] = 0;
				frame_pixels = 0;
				n_frames++;
				e.kind = KIND_THRESH;
				e.t0 = thresh_regs[0]; e.t1 = thresh_regs[1]; e.t2 = thresh_regs[2];
				e.mask = MASK_OFF;
				expected_results.push_back(e);
			end
		end
	endtask

	task automatic push_req(input logic req, input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2, input logic last);
		pending_reqs.push_back('{req, c0, c1, c2, last});
	endtask

	function automatic logic [7:0] pick_level(input int base, input int span);
		int v;
		v = base + $urandom_range(0, span);
		return (v > 255) ? 8'd255 : 8'(v);
	endfunction

	// Fill the request queue: directed cases, then random frames
	initial begin
		int added, npix, base[3], span[3], ncls;
		logic full;
		// classify before any frame: thresholds are zero
		push_req(REQ_CLASSIFY, 8'd0, 8'd0, 8'd0, 1'b0);
		push_req(REQ_CLASSIFY, 8'd255, 8'd255, 8'd255, 1'b1);
		push_req(REQ_CLASSIFY, 8'd1, 8'd255, 8'd0, 1'b0);
		// single-pixel frame gives all thresholds zero
		push_req(REQ_HIST, 8'd0, 8'd255, 8'd128, 1'b1);
		// flat frame
		for (int i = 0; i < 4; i++) push_req(REQ_HIST, 8'd77, 8'd77, 8'd77, i == 3);
		push_req(REQ_CLASSIFY, 8'd78, 8'd78, 8'd78, 1'b0);
		// extremes frame, with a classify during accumulation
		push_req(REQ_HIST, 8'd0, 8'd255, 8'd0, 1'b0);
		push_req(REQ_HIST, 8'd255, 8'd0, 8'd255, 1'b0);
		push_req(REQ_CLASSIFY, 8'd200, 8'd200, 8'd200, 1'b1);
		push_req(REQ_HIST, 8'd255, 8'd0, 8'd1, 1'b1);
		push_req(REQ_CLASSIFY, 8'd255, 8'd255, 8'd255, 1'b0);
		push_req(REQ_CLASSIFY, 8'd0, 8'd255, 8'd255, 1'b0);
		push_req(REQ_CLASSIFY, 8'd255, 8'd1, 8'd255, 1'b0);
		// two-level frame with ties
		push_req(REQ_HIST, 8'd10, 8'd20, 8'd30, 1'b0);
		push_req(REQ_HIST, 8'd10, 8'd20, 8'd30, 1'b0);
		push_req(REQ_HIST, 8'd11, 8'd200, 8'd31, 1'b1);
		push_req(REQ_CLASSIFY, 8'd11, 8'd200, 8'd31, 1'b0);
		push_req(REQ_CLASSIFY, 8'd10, 8'd199, 8'd30, 1'b0);

		added = 0;
		while (added < RAND_ITEMS) begin
			npix = $urandom_range(1, 16);
			full = ($urandom_range(0, 11) == 0);
			for (int c = 0; c < 3; c++) begin
				span[c] = full ? 255 : $urandom_range(0, 31);
				base[c] = full ? 0 : $urandom_range(0, 255);
			end
			for (int i = 0; i < npix; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					push_req(REQ_CLASSIFY, 8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom_range(0, 1)));
					added++;
				end
				push_req(REQ_HIST, pick_level(base[0], span[0]), pick_level(base[1], span[1]),
					pick_level(base[2], span[2]), i == npix - 1);
				added++;
			end
			ncls = $urandom_range(0, 8);
			for (int i = 0; i < ncls; i++) begin
				if ($urandom_range(0, 1))
					push_req(REQ_CLASSIFY, pick_level(base[0], span[0]),
						pick_level(base[1], span[1]), pick_level(base[2], span[2]),
						1'($urandom_range(0, 1)));
				else
					push_req(REQ_CLASSIFY, 8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom_range(0, 1)));
				added++;
			end
		end
	end

	// Reset once at the start
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Request driver: advance on acceptance, insert random gaps
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n && (in_fire || !in_valid)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				pixel_req_t r;
				int pick;
				r = pending_reqs.pop_front();
				req_type <= r.req;
				chan0_value <= r.c0;
				chan1_value <= r.c1;
				chan2_value <= r.c2;
				last_pixel <= r.last;
				in_valid <= 1'b1;
				pick = $urandom_range(0, 99);
				if (n_accepted > 800 && n_accepted < 1000) send_gap <= 0;
				else if (pick < 70) send_gap <= 0;
				else if (pick < 97) send_gap <= $urandom_range(1, 3);
				else send_gap <= $urandom_range(15, 50);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off once, so the block fills up and stalls its input
	int hold_left = 0;
	logic hold_done = 1'b0;
	always @(negedge clk) begin
		if (!hold_done && n_accepted >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			hold_active <= 1'b1;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
		end else begin
			hold_left <= 0;
			hold_active <= 1'b0;
		end
	end

	// Result stall: random lengths, a quiet window with none
	int stall_left = 0;
	always @(negedge clk) begin
		int pick;
		pick = $urandom_range(0, 99);
		if (hold_active) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (n_accepted > 800 && n_accepted < 1000) begin
			out_stall <= 1'b0;
		end else if (pick < 75) begin
			out_stall <= 1'b0;
		end else if (pick < 97) begin
			stall_left <= $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			stall_left <= $urandom_range(20, 60);
			out_stall <= 1'b1;
		end
	end

	// Monitor: check accepted results, then predict from accepted requests
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (out_valid && !out_stall) begin
			n_results++;
			if (expected_results.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result kind %0d t %0d/%0d/%0d mask %0d", $realtime,
					result_kind, thresh0, thresh1, thresh2, mask_value);
			end else begin
				otsu_result_t e;
				e = expected_results.pop_front();
				if (e !== {result_kind, thresh0, thresh1, thresh2, mask_value}) begin
					n_errors++;
					$display("%0t: result mismatch expected kind %0d t %0d/%0d/%0d mask %0d,",
						$realtime, e.kind, e.t0, e.t1, e.t2, e.mask);
					$display("    actual kind %0d t %0d/%0d/%0d mask %0d",
						result_kind, thresh0, thresh1, thresh2, mask_value);
				end
			end
		end
		if (in_valid && !in_stall) begin
			n_accepted++;
			predict_request({req_type, chan0_value, chan1_value, chan2_value, last_pixel});
		end
	end

	// Drain and report
	initial begin
		for (int c = 0; c < 3; c++) begin
			thresh_regs[c] = '0;
			for (int k = 0; k < NUM_LEVELS; k++) hist_bins[c][k] = 0;
		end
		frame_pixels = 0;
		wait (arst_n);
		#1;
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d requests over %0d frames, %0d results checked, %0d errors.",
			n_accepted, n_frames, n_results, n_errors + expected_results.size());
		if (n_errors == 0 && expected_results.size() == 0)
			$display("PASS otsu_threshold_rgb_mask");
		else
			$display("FAIL otsu_threshold_rgb_mask");
		$finish;
	end

	// Watchdog
	initial begin
		#300ms;
		$display("Timeout with %0d results outstanding.", expected_results.size());
		$display("FAIL otsu_threshold_rgb_mask");
		$finish;
	end

endmodule
